// ----- rtl/rspe_pkg.sv -----
`timescale 1ns / 1ps

package rspe_pkg;

	// Field polynomial x^8+x^4+x^3+x^2+1 without the top bit.
	localparam logic [7:0] FIELD_POLY_LO = 8'h1D;

	// Parity count loaded by reset.
	localparam logic [5:0] RESET_COUNT = 6'd7;

	// Generator build sequencer states.
	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_BUILD = 3'b010,
		ST_READY = 3'b100
	} gen_state_t;

	// Status from the build sequencer to the datapath.
	typedef struct packed {
		logic       load;
		logic       build;
		logic       ready;
		logic [7:0] root;
	} seq_stat_t;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic       load;
		logic       build;
		logic       step;
		logic       flush;
		logic       drain;
		logic [7:0] mul_b;
	} cell_ctrl_t;

	// Multiply by alpha in GF(256).
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LO : 8'h00);
	endfunction

	// Shift-and-add multiply in GF(256).
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x   = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		gf_mul = acc;
	endfunction

endpackage

// ----- rtl/rspe_cell.sv -----
`timescale 1ns / 1ps

module rspe_cell #(
	parameter int MAX_PARITY = 32,
	parameter int IDX        = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(MAX_PARITY+1)-1:0]    n,
	input  rspe_pkg::cell_ctrl_t               ctl,
	input  logic [7:0]                         gen_nb,
	input  logic [7:0]                         rem_nb,
	input  logic [7:0]                         out_nb,
	output logic [7:0]                         gen,
	output logic [7:0]                         rem,
	output logic [7:0]                         par
);
	import rspe_pkg::*;

	localparam int CW = $clog2(MAX_PARITY + 1);
	localparam logic [CW-1:0] POS  = CW'(IDX);
	localparam logic [CW-1:0] NEXT = CW'(IDX + 1);

	logic [7:0] gen_q;
	logic [7:0] rem_q;
	logic [7:0] par_q;
	logic       act;
	logic       tail;
	logic [7:0] prod;
	logic [7:0] rem_next;

	// This cell takes part in the division when it lies below the count.
	assign act  = (POS < n);
	assign tail = (NEXT == n);

	// One shared multiplier: root during the build, feedback while encoding.
	assign prod     = gf_mul(gen_q, ctl.mul_b);
	assign rem_next = (tail ? 8'h00 : rem_nb) ^ prod;

	// Generator coefficient, stored aligned so that cell j meets term n-1-j.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			gen_q <= tail ? 8'h01 : 8'h00;
		end else if (ctl.build) begin
			gen_q <= gen_nb ^ prod;
		end
	end

	// Remainder symbol; the whole row clears at the end of a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 8'h00;
		end else if (ctl.step) begin
			if (ctl.flush) begin
				rem_q <= 8'h00;
			end else if (act) begin
				rem_q <= rem_next;
			end
		end
	end

	// Parity output shift line, loaded with the final remainder.
	always_ff @(posedge clk) begin
		if (ctl.step && ctl.flush) begin
			par_q <= rem_next;
		end else if (ctl.drain) begin
			par_q <= out_nb;
		end
	end

	assign gen = gen_q;
	assign rem = rem_q;
	assign par = par_q;

endmodule

// ----- rtl/rspe_seq.sv -----
`timescale 1ns / 1ps

module rspe_seq #(
	parameter int MAX_PARITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [5:0]                         parity_count,
	output logic [$clog2(MAX_PARITY+1)-1:0]    n,
	output rspe_pkg::seq_stat_t                stat
);
	import rspe_pkg::*;

	localparam int CW = $clog2(MAX_PARITY + 1);
	localparam logic [6:0] MAX7 = 7'(MAX_PARITY);

	gen_state_t    state_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] iter_q;
	logic [7:0]    root_q;
	logic [6:0]    wr_ext;
	logic [6:0]    wr_clamp;
	logic [6:0]    rst_clamp;

	// Clamp a written count to the range one to MAX_PARITY.
	assign wr_ext   = {1'b0, parity_count};
	assign wr_clamp = (wr_ext == 7'd0) ? 7'd1 : ((wr_ext > MAX7) ? MAX7 : wr_ext);
	assign rst_clamp = ({1'b0, RESET_COUNT} > MAX7) ? MAX7 : {1'b0, RESET_COUNT};

	// Count register and generator build sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q     <= CW'(rst_clamp);
			iter_q  <= '0;
			root_q  <= 8'h01;
		end else if (cfg_write_en) begin
			state_q <= ST_LOAD;
			n_q     <= CW'(wr_clamp);
		end else begin
			case (state_q)
				ST_LOAD: begin
					iter_q  <= '0;
					root_q  <= 8'h01;
					state_q <= ST_BUILD;
				end
				ST_BUILD: begin
					iter_q <= iter_q + 1'b1;
					root_q <= gf_xtime(root_q);
					if (iter_q == n_q - 1'b1) begin
						state_q <= ST_READY;
					end
				end
				ST_READY: begin
					state_q <= ST_READY;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign n          = n_q;
	assign stat.load  = (state_q == ST_LOAD);
	assign stat.build = (state_q == ST_BUILD);
	assign stat.ready = (state_q == ST_READY);
	assign stat.root  = root_q;

endmodule

// ----- rtl/reed_solomon_parity_encoder_unit.sv -----
`timescale 1ns / 1ps
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// Input channel: data_valid / data_stall carry one message word per cycle,
// data_byte and last_byte; last_byte marks the final word of a block.
// Output channel: parity_valid / parity_stall carry the parity words,
// highest degree first; last_parity marks the final one of the block.
// Configuration: cfg_write_en writes parity_count (clamped to 1..MAX_PARITY).
// Throughput: one data word per cycle while data_stall is low, set by the row
// of cells that each update one remainder symbol with one GF multiplier per word.
// Latency: the first parity word is valid the cycle after the last data word
// is accepted; the block's n parity words leave one per cycle unless stalled.
// A new block's data flows while parity drains; a last word is held off
// (data_stall high) until the previous block's parity has all been taken.
// Reset clears the remainder and loads count 7; reset and each write of
// parity_count rebuild the generator in the cells, through the load and
// build states, during which data_stall stays high.
// When the receiver stalls, the parity word and last_parity hold steady.
module reed_solomon_parity_encoder_unit #(
	parameter int MAX_PARITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [5:0] parity_count,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       parity_valid,
	input  logic       parity_stall,
	output logic [7:0] parity_byte,
	output logic       last_parity
);
	import rspe_pkg::*;

	localparam int CW = $clog2(MAX_PARITY + 1);

	seq_stat_t     stat;
	cell_ctrl_t    ctl;
	logic [CW-1:0] n;
	logic [CW-1:0] out_cnt_q;
	logic          in_acc;
	logic          out_acc;
	logic [7:0]    gen_w [MAX_PARITY+1];
	logic [7:0]    rem_w [MAX_PARITY+1];
	logic [7:0]    par_w [MAX_PARITY+1];

	// Generator build sequencer and count register.
	rspe_seq #(.MAX_PARITY(MAX_PARITY)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.parity_count (parity_count),
		.n            (n),
		.stat         (stat)
	);

	// Handshakes.
	assign data_stall = !stat.ready || (last_byte && (out_cnt_q != '0));
	assign in_acc     = data_valid && !data_stall;
	assign out_acc    = parity_valid && !parity_stall;

	// Broadcast control for the row.
	assign ctl.load  = stat.load;
	assign ctl.build = stat.build;
	assign ctl.step  = in_acc;
	assign ctl.flush = last_byte;
	assign ctl.drain = out_acc;
	assign ctl.mul_b = stat.build ? stat.root : (data_byte ^ rem_w[0]);

	// Row end sees zeros beyond the last cell.
	assign gen_w[MAX_PARITY] = 8'h00;
	assign rem_w[MAX_PARITY] = 8'h00;
	assign par_w[MAX_PARITY] = 8'h00;

	// Row of cells, each holding one remainder and one generator symbol.
	for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
		rspe_cell #(.MAX_PARITY(MAX_PARITY), .IDX(j)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.n      (n),
			.ctl    (ctl),
			.gen_nb (gen_w[j+1]),
			.rem_nb (rem_w[j+1]),
			.out_nb (par_w[j+1]),
			.gen    (gen_w[j]),
			.rem    (rem_w[j]),
			.par    (par_w[j])
		);
	end

	// Parity words still to deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (in_acc && last_byte) begin
			out_cnt_q <= n;
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

	assign parity_valid = (out_cnt_q != '0);
	assign parity_byte  = par_w[0];
	assign last_parity  = (out_cnt_q == CW'(1));

	// Data is never taken while the generator is being rebuilt.
	a_no_take_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> stat.ready)
		else $error("data word accepted during generator build");

	// A completed block always yields parity on the next cycle.
	a_parity_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_byte) |=> (parity_valid && (out_cnt_q == $past(n))))
		else $error("parity not presented after last data word");

	// A count write holds off data while the generator is rebuilt.
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en |=> data_stall)
		else $error("data not stalled after count write");

endmodule
